// ===== design/netstring_deframer_assert.svh =====
// Assertion macros used by the netstring deframer parser
`ifndef NETSTRING_DEFRAMER_ASSERT_SVH
`define NETSTRING_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition that must hold at every clock edge out of reset
`define NSD_ASSERT_HOLD(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("netstring_deframer: invariant violated");

// Check that a cause is followed by an effect in the cycle after it
`define NSD_ASSERT_NEXT(lbl, clk, rst, cause, effect) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error("netstring_deframer: sequence violated");

`else

`define NSD_ASSERT_HOLD(lbl, clk, rst, cond)
`define NSD_ASSERT_NEXT(lbl, clk, rst, cause, effect)

`endif

`endif

// ===== design/nsd_pkg.sv =====
// Types and constants of the netstring deframer
`timescale 1ns / 1ps

package nsd_pkg;

   localparam int LIMIT_W = 20;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd65535;

   // result kinds
   localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
   localparam logic [2:0] KIND_OK         = 3'd1;
   localparam logic [2:0] KIND_BAD_HEADER = 3'd2;
   localparam logic [2:0] KIND_EMPTY      = 3'd3;
   localparam logic [2:0] KIND_NO_COMMA   = 3'd4;
   localparam logic [2:0] KIND_TOO_LONG   = 3'd5;

   // framing characters
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;

   // byte held in the input register
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } byte_slot_type;

   // result register contents
   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [7:0] data;
      logic       fin;
   } result_type;

endpackage

// ===== design/nsd_if.sv =====
// Channel interfaces of the netstring deframer
`timescale 1ns / 1ps

interface nsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface nsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] result_kind;
   logic [7:0] payload_byte;
   logic       final_payload;

   modport source (output valid, output result_kind, output payload_byte,
                   output final_payload, input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input final_payload, output ready);
endinterface

interface nsd_csr_if;
   logic                         valid;
   logic                         ready;
   logic [nsd_pkg::LIMIT_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== design/nsd_in_reg.sv =====
// Input register stage of the netstring deframer
`timescale 1ns / 1ps

module nsd_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   input  logic [7:0]             up_data,
   output logic                   up_ready,
   output nsd_pkg::byte_slot_type slot,
   input  logic                   down_ready
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic       load;

   // accept while empty or while the held byte moves on this cycle
   assign up_ready = !valid_ff || down_ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (down_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the byte until it is consumed
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= up_data;
      end
   end

   assign slot.valid = valid_ff;
   assign slot.data  = data_ff;

endmodule

// ===== design/nsd_parser.sv =====
// Frame parser: phase and count state, length limit and result register
`timescale 1ns / 1ps

`include "netstring_deframer_assert.svh"

module nsd_parser #(
   parameter int COUNT_WIDTH = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nsd_pkg::byte_slot_type        slot,
   output logic                          slot_ready,
   input  logic                          csr_valid,
   input  logic [nsd_pkg::LIMIT_W-1:0]   csr_data,
   output nsd_pkg::result_type           result,
   input  logic                          result_ready
);

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_TRAILER = 2'd2;

   localparam int EXT_W = COUNT_WIDTH + 4;
   localparam int CMP_W = (EXT_W > nsd_pkg::LIMIT_W) ? EXT_W : nsd_pkg::LIMIT_W;

   logic [1:0]                  phase_ff;
   logic [1:0]                  phase_in;
   logic [COUNT_WIDTH-1:0]      count_ff;
   logic [COUNT_WIDTH-1:0]      count_in;
   logic [nsd_pkg::LIMIT_W-1:0] limit_ff;
   nsd_pkg::result_type         result_ff;
   nsd_pkg::result_type         result_in;

   logic                        fire;
   logic                        emit;
   logic [2:0]                  kind;
   logic [7:0]                  data;
   logic                        fin;
   logic                        last;
   logic                        is_digit;
   logic [EXT_W-1:0]            count_ext;
   logic [EXT_W-1:0]            next_len;
   logic                        too_long;

   // consume a byte whenever the result register can take its outcome
   assign slot_ready = !result_ff.valid || result_ready;
   assign fire       = slot.valid && slot_ready;

   // header arithmetic: times ten as two shifts and an add
   assign count_ext = EXT_W'(count_ff);
   assign next_len  = (count_ext << 3) + (count_ext << 1) + EXT_W'(slot.data[3:0]);
   assign too_long  = (CMP_W'(next_len) > CMP_W'(limit_ff))
                      || (next_len[EXT_W-1:COUNT_WIDTH] != 4'd0);
   assign is_digit  = (slot.data >= nsd_pkg::CHAR_ZERO) && (slot.data <= nsd_pkg::CHAR_NINE);
   assign last      = count_ff <= COUNT_WIDTH'(1);

   // per-byte state update and result selection
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      emit     = 1'b0;
      kind     = nsd_pkg::KIND_PAYLOAD;
      data     = 8'd0;
      fin      = 1'b0;
      case (phase_ff)
         PH_PAYLOAD: begin
            emit = 1'b1;
            data = slot.data;
            fin  = last;
            if (last) begin
               count_in = '0;
               phase_in = PH_TRAILER;
            end else begin
               count_in = count_ff - COUNT_WIDTH'(1);
            end
         end
         PH_TRAILER: begin
            emit     = 1'b1;
            kind     = (slot.data == nsd_pkg::CHAR_COMMA) ? nsd_pkg::KIND_OK
                                                          : nsd_pkg::KIND_NO_COMMA;
            phase_in = PH_HEADER;
            count_in = '0;
         end
         default: begin
            phase_in = PH_HEADER;
            if (is_digit) begin
               if (too_long) begin
                  emit     = 1'b1;
                  kind     = nsd_pkg::KIND_TOO_LONG;
                  count_in = '0;
               end else begin
                  count_in = next_len[COUNT_WIDTH-1:0];
               end
            end else if (slot.data == nsd_pkg::CHAR_COLON) begin
               if (count_ff == '0) begin
                  emit = 1'b1;
                  kind = nsd_pkg::KIND_EMPTY;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end else begin
               emit     = 1'b1;
               kind     = nsd_pkg::KIND_BAD_HEADER;
               count_in = '0;
            end
         end
      endcase
   end

   // load a new result, or drop the old one once transferred
   always_comb begin
      result_in = result_ff;
      if (fire && emit) begin
         result_in.valid = 1'b1;
         result_in.kind  = kind;
         result_in.data  = data;
         result_in.fin   = fin;
      end else if (result_ready) begin
         result_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         count_ff  <= '0;
         limit_ff  <= nsd_pkg::LIMIT_RESET;
         result_ff <= '0;
      end else begin
         if (fire) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
         end
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

   `NSD_ASSERT_HOLD(a_payload_count_nonzero, clock, reset,
      (phase_ff != PH_PAYLOAD) || (count_ff != '0))
   `NSD_ASSERT_HOLD(a_trailer_count_zero, clock, reset,
      (phase_ff != PH_TRAILER) || (count_ff == '0))
   `NSD_ASSERT_HOLD(a_final_only_on_payload, clock, reset,
      !(result_ff.valid && result_ff.fin) || (result_ff.kind == nsd_pkg::KIND_PAYLOAD))
   `NSD_ASSERT_NEXT(a_last_byte_to_trailer, clock, reset,
      fire && (phase_ff == PH_PAYLOAD) && last,
      (phase_ff == PH_TRAILER) && result_ff.valid && result_ff.fin)

endmodule

// ===== design/netstring_deframer.sv =====
// Path: a byte transferred on req reaches rsp through the input register, then the result
// register; header digits within the length limit and a colon that opens a frame give no result.
// Throughput: one byte per cycle while rsp accepts results, set by the phase and count update.
// Reset (synchronous, active high): header phase, count zero, both stages empty,
// length limit 65535. No clearing pass; the block is ready the cycle after reset.
`timescale 1ns / 1ps

module netstring_deframer #(
   parameter int COUNT_WIDTH = 20
) (
   input  logic             clock,
   input  logic             reset,
   nsd_req_if.sink          req_if,
   nsd_rsp_if.source        rsp_if,
   nsd_csr_if.sink          csr_if
);

   nsd_pkg::byte_slot_type slot;
   logic                   slot_ready;
   nsd_pkg::result_type    result;

   // input register
   nsd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_if.valid),
      .up_data    (req_if.in_byte),
      .up_ready   (req_if.ready),
      .slot       (slot),
      .down_ready (slot_ready)
   );

   // parser and result register
   nsd_parser #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .slot         (slot),
      .slot_ready   (slot_ready),
      .csr_valid    (csr_if.valid),
      .csr_data     (csr_if.data),
      .result       (result),
      .result_ready (rsp_if.ready)
   );

   // register writes are always accepted; the limit register loads the data
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid         = result.valid;
   assign rsp_if.result_kind   = result.kind;
   assign rsp_if.payload_byte  = result.data;
   assign rsp_if.final_payload = result.fin;

endmodule
